>>> rtl/core/dependency_topological_order_assert.svh
// Assertion macros for the dependency scheduler.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef DEPENDENCY_TOPOLOGICAL_ORDER_ASSERT_SVH
`define DEPENDENCY_TOPOLOGICAL_ORDER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DTO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/dto_pkg.sv
// Shared types and constants for the dependency scheduler.
// No dependencies; every other file of the block but the assertion macro header uses it.
`default_nettype none

package dto_pkg;

  localparam int CELL_W           = 4;
  localparam int MAX_CELLS        = 16;
  localparam int CNT_W            = 5;
  localparam int PTR_W            = 5;
  localparam int IDX_W            = 7;
  localparam int DEF_GRID_ROWS    = 4;
  localparam int DEF_GRID_COLUMNS = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_POP,
    ST_EMIT,
    ST_VISIT,
    ST_SUMMARY
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic seed;
    logic pop;
    logic emit;
    logic visit;
    logic summary;
  } cmd_t;

  typedef struct packed {
    logic seed_last;
    logic q_empty;
    logic visit_last;
    logic out_busy;
  } sts_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_index;
    logic [CELL_W-1:0] ref_index;
    logic              has_ref;
    logic              has_formula;
    logic              last;
  } in_beat_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_index_res;
    logic              summary_item;
    logic              circular;
    logic              last_res;
  } out_beat_t;

endpackage

`default_nettype wire

>>> rtl/core/dto_intf.sv
// Valid/ready channel interfaces for the load beats and the schedule beats.
// Depends on dto_pkg for the field widths.
`default_nettype none

interface dto_in_if;
  logic                       valid;
  logic                       ready;
  logic [dto_pkg::CELL_W-1:0] cell_index;
  logic [dto_pkg::CELL_W-1:0] ref_index;
  logic                       has_ref;
  logic                       has_formula;
  logic                       last;

  modport source (output valid, cell_index, ref_index, has_ref, has_formula, last,
                  input ready);
  modport sink (input valid, cell_index, ref_index, has_ref, has_formula, last,
                output ready);
endinterface

interface dto_out_if;
  logic                       valid;
  logic                       ready;
  logic [dto_pkg::CELL_W-1:0] cell_index_res;
  logic                       summary_item;
  logic                       circular;
  logic                       last_res;

  modport source (output valid, cell_index_res, summary_item, circular, last_res,
                  input ready);
  modport sink (input valid, cell_index_res, summary_item, circular, last_res,
                output ready);
endinterface

`default_nettype wire

>>> rtl/core/dependency_topological_order.sv
// Solve: after the last load beat the controller scans every grid cell to seed the ready
// queue, then per scheduled cell pops, emits and visits the count table, then a summary beat.
// Throughput: one load beat per cycle while idle, none during a solve, which is bound by the
// one-dependent-per-cycle visit of the count table. Output stalls hold emit and summary.
// Reset: asynchronous, active low; clears the graph, counts, queue pointers and output valid.
// Uses dto_pkg, dto_intf, dto_ctrl, dto_datapath and the assertion macro header.
`default_nettype none

`include "dependency_topological_order_assert.svh"

module dependency_topological_order #(
  parameter int GRID_ROWS    = dto_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLUMNS = dto_pkg::DEF_GRID_COLUMNS
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  dto_in_if.sink    in_i,
  dto_out_if.source out_o
);

  dto_pkg::cmd_t      cmd;
  dto_pkg::sts_t      sts;
  dto_pkg::in_beat_t  in_beat;
  dto_pkg::out_beat_t out_beat;
  logic               in_ready;
  logic               out_valid;

  always_comb begin
    in_beat.cell_index  = in_i.cell_index;
    in_beat.ref_index   = in_i.ref_index;
    in_beat.has_ref     = in_i.has_ref;
    in_beat.has_formula = in_i.has_formula;
    in_beat.last        = in_i.last;
  end

  dto_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dto_datapath #(
    .GRID_ROWS    (GRID_ROWS),
    .GRID_COLUMNS (GRID_COLUMNS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_beat_i   (in_beat),
    .out_beat_o  (out_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready)
  );

  assign in_i.ready           = in_ready;
  assign out_o.valid          = out_valid;
  assign out_o.cell_index_res = out_beat.cell_index_res;
  assign out_o.summary_item   = out_beat.summary_item;
  assign out_o.circular       = out_beat.circular;
  assign out_o.last_res       = out_beat.last_res;

  `DTO_ASSERT_NOW(a_summary_form, out_o.valid && out_o.summary_item,
    out_o.last_res && (out_o.cell_index_res == '0), "summary beat malformed")
  `DTO_ASSERT_NOW(a_cell_form, out_o.valid && !out_o.summary_item,
    !out_o.circular && !out_o.last_res, "cell beat carries summary flags")
  `DTO_ASSERT_NEXT(a_solve_blocks_load, in_i.valid && in_i.ready && in_i.last,
    !in_i.ready, "load accepted right after the last beat")
  `DTO_ASSERT_NOW(a_pop_nonempty, cmd.pop, !sts.q_empty, "pop from empty ready queue")

endmodule

`default_nettype wire

>>> rtl/core/dto_datapath.sv
// Datapath: dependency matrix, unresolved counts, ready queue, scan counters
// and the output register. Driven by dto_ctrl commands; uses dto_pkg.
`default_nettype none

module dto_datapath #(
  parameter int GRID_ROWS    = dto_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLUMNS = dto_pkg::DEF_GRID_COLUMNS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dto_pkg::cmd_t     cmd_i,
  output dto_pkg::sts_t          sts_o,
  input  wire dto_pkg::in_beat_t in_beat_i,
  output dto_pkg::out_beat_t     out_beat_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i
);

  localparam int NCELLS = (GRID_ROWS * GRID_COLUMNS < dto_pkg::MAX_CELLS) ?
                          GRID_ROWS * GRID_COLUMNS : dto_pkg::MAX_CELLS;
  localparam int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int CW = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
  localparam logic [RW-1:0] R_LAST = RW'(GRID_ROWS - 1);
  localparam logic [CW-1:0] C_LAST = CW'(GRID_COLUMNS - 1);
  localparam logic [dto_pkg::CELL_W-1:0] D_LAST = dto_pkg::CELL_W'(NCELLS - 1);
  localparam logic [dto_pkg::CELL_W:0] NC_EXT = (dto_pkg::CELL_W + 1)'(NCELLS);
  localparam logic [dto_pkg::IDX_W-1:0] NC_IDX = dto_pkg::IDX_W'(NCELLS);

  logic [dto_pkg::MAX_CELLS-1:0] dep_q [dto_pkg::MAX_CELLS];
  logic [dto_pkg::CNT_W-1:0]     cnt_q [dto_pkg::MAX_CELLS];
  logic [dto_pkg::MAX_CELLS-1:0] formula_q;
  logic [dto_pkg::CELL_W-1:0]    queue_mem [dto_pkg::MAX_CELLS];
  logic [dto_pkg::PTR_W-1:0]     head_q, tail_q;
  logic [dto_pkg::CNT_W-1:0]     total_q;
  logic [RW-1:0]                 r_q;
  logic [CW-1:0]                 c_q;
  logic [dto_pkg::CELL_W-1:0]    d_q;
  logic [dto_pkg::CELL_W-1:0]    cur_q;
  logic                          out_valid_q;
  dto_pkg::out_beat_t            out_beat_q;

  logic                          cell_ok, ref_ok, dup;
  logic [dto_pkg::IDX_W-1:0]     seed_idx;
  logic [dto_pkg::CELL_W-1:0]    seed_cell;
  logic                          idx_ok, seed_cnt_nz, push_seed, seed_inc;
  logic                          visit_hit, push_visit;
  logic                          push;
  logic [dto_pkg::CELL_W-1:0]    push_data;
  logic                          seed_last, visit_last;

  always_comb begin
    cell_ok     = {1'b0, in_beat_i.cell_index} < NC_EXT;
    ref_ok      = {1'b0, in_beat_i.ref_index} < NC_EXT;
    dup         = dep_q[in_beat_i.ref_index][in_beat_i.cell_index];
    seed_idx    = dto_pkg::IDX_W'(c_q) * dto_pkg::IDX_W'(GRID_ROWS) + dto_pkg::IDX_W'(r_q);
    seed_cell   = seed_idx[dto_pkg::CELL_W-1:0];
    idx_ok      = seed_idx < NC_IDX;
    seed_cnt_nz = cnt_q[seed_cell] != '0;
    push_seed   = idx_ok && !seed_cnt_nz && formula_q[seed_cell];
    seed_inc    = idx_ok && (seed_cnt_nz || formula_q[seed_cell]);
    visit_hit   = dep_q[cur_q][d_q] && (cnt_q[d_q] != '0);
    push_visit  = visit_hit && (cnt_q[d_q] == dto_pkg::CNT_W'(1));
    push        = (cmd_i.seed && push_seed) || (cmd_i.visit && push_visit);
    push_data   = cmd_i.seed ? seed_cell : d_q;
    seed_last   = (r_q == R_LAST) && (c_q == C_LAST);
    visit_last  = d_q == D_LAST;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dto_pkg::MAX_CELLS; i++) begin
        dep_q[i] <= '0;
        cnt_q[i] <= '0;
      end
      formula_q <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      total_q   <= '0;
      r_q       <= '0;
      c_q       <= '0;
      d_q       <= '0;
    end else if (cmd_i.summary) begin
      for (int i = 0; i < dto_pkg::MAX_CELLS; i++) begin
        dep_q[i] <= '0;
        cnt_q[i] <= '0;
      end
      formula_q <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      total_q   <= '0;
    end else begin
      if (cmd_i.load && cell_ok) begin
        if (in_beat_i.has_formula) begin
          formula_q[in_beat_i.cell_index] <= 1'b1;
        end
        if (in_beat_i.has_ref && ref_ok && !dup) begin
          dep_q[in_beat_i.ref_index][in_beat_i.cell_index] <= 1'b1;
          cnt_q[in_beat_i.cell_index] <= cnt_q[in_beat_i.cell_index] + dto_pkg::CNT_W'(1);
        end
      end
      if (cmd_i.seed) begin
        if (c_q == C_LAST) begin
          c_q <= '0;
          r_q <= (r_q == R_LAST) ? '0 : r_q + RW'(1);
        end else begin
          c_q <= c_q + CW'(1);
        end
        if (seed_inc) begin
          total_q <= total_q + dto_pkg::CNT_W'(1);
        end
      end
      if (push) begin
        tail_q <= tail_q + dto_pkg::PTR_W'(1);
      end
      if (cmd_i.pop) begin
        head_q <= head_q + dto_pkg::PTR_W'(1);
        if (total_q != '0) begin
          total_q <= total_q - dto_pkg::CNT_W'(1);
        end
      end
      if (cmd_i.visit) begin
        d_q <= visit_last ? '0 : d_q + dto_pkg::CELL_W'(1);
        if (visit_hit) begin
          cnt_q[d_q] <= cnt_q[d_q] - dto_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_mem[tail_q[dto_pkg::CELL_W-1:0]] <= push_data;
    end
    if (cmd_i.pop) begin
      cur_q <= queue_mem[head_q[dto_pkg::CELL_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.summary) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_beat_q.cell_index_res <= cur_q;
      out_beat_q.summary_item   <= 1'b0;
      out_beat_q.circular       <= 1'b0;
      out_beat_q.last_res       <= 1'b0;
    end else if (cmd_i.summary) begin
      out_beat_q.cell_index_res <= '0;
      out_beat_q.summary_item   <= 1'b1;
      out_beat_q.circular       <= total_q != '0;
      out_beat_q.last_res       <= 1'b1;
    end
  end

  always_comb begin
    sts_o.seed_last  = seed_last;
    sts_o.q_empty    = head_q == tail_q;
    sts_o.visit_last = visit_last;
    sts_o.out_busy   = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

`default_nettype wire

>>> rtl/core/dto_ctrl.sv
// Controller state machine: load, seed scan, pop, emit, dependent visit, summary.
// Issues dto_pkg::cmd_t to dto_datapath and reads its dto_pkg::sts_t.
`default_nettype none

module dto_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_last_i,
  output logic               in_ready_o,
  input  wire dto_pkg::sts_t sts_i,
  output dto_pkg::cmd_t      cmd_o
);

  dto_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dto_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      dto_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            state_d = dto_pkg::ST_SEED;
          end
        end
      end
      dto_pkg::ST_SEED: begin
        cmd_o.seed = 1'b1;
        if (sts_i.seed_last) begin
          state_d = dto_pkg::ST_POP;
        end
      end
      dto_pkg::ST_POP: begin
        if (sts_i.q_empty) begin
          state_d = dto_pkg::ST_SUMMARY;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = dto_pkg::ST_EMIT;
        end
      end
      dto_pkg::ST_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = dto_pkg::ST_VISIT;
        end
      end
      dto_pkg::ST_VISIT: begin
        cmd_o.visit = 1'b1;
        if (sts_i.visit_last) begin
          state_d = dto_pkg::ST_POP;
        end
      end
      dto_pkg::ST_SUMMARY: begin
        if (!sts_i.out_busy) begin
          cmd_o.summary = 1'b1;
          state_d       = dto_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dto_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
